@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the covariance block, used by its core module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/wpcc_pkg.sv @@
// Shared widths, types and operation codes of the weighted point cluster covariance block.
package wpcc_pkg;

   localparam int COORD_BITS  = 16;
   localparam int WEIGHT_BITS = 16;
   localparam int FRAC_BITS   = 8;

   localparam int MEAN_W = 24;
   localparam int TOT_W  = 32;
   localparam int VAR_W  = 47;
   localparam int COV_W  = 48;

   localparam int PT_W   = COORD_BITS + FRAC_BITS;
   localparam int DIFF_W = PT_W + 1;
   localparam int SUM_W  = TOT_W + 1;

   // Shared unit operand widths: B holds a divisor or a multiplier, the
   // quotient is known to stay below 2^QUO_W.
   localparam int OPB_W = 34;
   localparam int QUO_W = 50;
   localparam int OPA_W = OPB_W + QUO_W;

   localparam int REQ_BITS    = 3 * COORD_BITS + WEIGHT_BITS;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = 3 * MEAN_W + TOT_W + 3 * VAR_W + 3 * COV_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic {
      AR_MUL,
      AR_DIV
   } wpcc_op_type;

   typedef struct packed {
      logic             start;
      wpcc_op_type      op;
      logic [OPA_W-1:0] a;
      logic [OPB_W-1:0] b;
   } wpcc_arith_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [OPA_W-1:0] result;
   } wpcc_arith_rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic [WEIGHT_BITS-1:0]       weight;
      logic                         start_new;
   } wpcc_point_type;

   typedef struct packed {
      logic signed [MEAN_W-1:0] mean_x;
      logic signed [MEAN_W-1:0] mean_y;
      logic signed [MEAN_W-1:0] mean_z;
      logic [TOT_W-1:0]         weight_sum;
      logic [VAR_W-1:0]         var_xx;
      logic [VAR_W-1:0]         var_yy;
      logic [VAR_W-1:0]         var_zz;
      logic signed [COV_W-1:0]  cov_xy;
      logic signed [COV_W-1:0]  cov_yz;
      logic signed [COV_W-1:0]  cov_zx;
      logic                     fault;
   } wpcc_result_type;

endpackage

@@ hw/rtl/wpcc_arith.sv @@
// Shared shift-add multiplier and rounding restoring divider, one bit per cycle.
module wpcc_arith import wpcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  wpcc_arith_req_type req,
   output wpcc_arith_rsp_type rsp
);

   typedef enum logic [1:0] {
      AR_IDLE,
      AR_LOAD,
      AR_RUN
   } phase_type;

   localparam int CNT_W = $clog2(QUO_W + 1);

   phase_type        phase_ff, phase_in;
   wpcc_op_type      op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [OPA_W-1:0] acc_ff, acc_in;
   logic [OPA_W-1:0] mc_ff, mc_in;
   logic [OPB_W-1:0] mp_ff, mp_in;
   logic [OPB_W-1:0] rem_ff, rem_in;
   logic             done_ff, done_in;
   logic [OPB_W:0]   trial;

   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      mc_in    = mc_ff;
      mp_in    = mp_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, acc_ff[OPA_W-1]};
      case (phase_ff)
         AR_IDLE: begin
            if (req.start) begin
               op_in = req.op;
               mp_in = req.b;
               if (req.op == AR_MUL) begin
                  acc_in   = '0;
                  mc_in    = req.a;
                  cnt_in   = CNT_W'(OPB_W);
                  phase_in = AR_RUN;
               end else begin
                  // Adding half the divisor makes the truncating divide round.
                  acc_in   = req.a + OPA_W'(req.b >> 1);
                  phase_in = AR_LOAD;
               end
            end
         end
         AR_LOAD: begin
            // The quotient fits in QUO_W bits, so the top bits start below the divisor.
            rem_in   = acc_ff[OPA_W-1:QUO_W];
            acc_in   = {acc_ff[QUO_W-1:0], {OPB_W{1'b0}}};
            cnt_in   = CNT_W'(QUO_W);
            phase_in = AR_RUN;
         end
         AR_RUN: begin
            if (op_ff == AR_MUL) begin
               if (mp_ff[0]) begin
                  acc_in = acc_ff + mc_ff;
               end
               mc_in = mc_ff << 1;
               mp_in = mp_ff >> 1;
            end else begin
               if (trial >= {1'b0, mp_ff}) begin
                  rem_in = OPB_W'(trial - {1'b0, mp_ff});
                  acc_in = {acc_ff[OPA_W-2:0], 1'b1};
               end else begin
                  rem_in = trial[OPB_W-1:0];
                  acc_in = {acc_ff[OPA_W-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               phase_in = AR_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            phase_in = AR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      rem_ff <= rem_in;
      if (reset) begin
         phase_ff <= AR_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   assign rsp.busy   = (phase_ff != AR_IDLE);
   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff;

endmodule

@@ hw/rtl/wpcc_core.sv @@
// Cluster state and the sequencer that runs the mean and covariance update over the shared unit.
module wpcc_core import wpcc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  wpcc_point_type  in_point,
   output logic            out_valid,
   input  logic            out_ready,
   output wpcc_result_type result
);

`include "assert_macros.svh"

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN_MUL,
      ST_MEAN_DIV,
      ST_T1_MUL,
      ST_T1_DIV,
      ST_DD_MUL,
      ST_PW_MUL,
      ST_PW_DIV,
      ST_PWW_MUL,
      ST_PWW_DIV,
      ST_DONE
   } state_type;

   localparam logic signed [COV_W+1:0] COV_HI = (COV_W+2)'((64'sd1 <<< (COV_W - 1)) - 64'sd1);
   localparam logic signed [COV_W+1:0] COV_LO = (COV_W+2)'(-(64'sd1 <<< (COV_W - 1)));
   localparam logic [OPA_W-1:0]        RND_HALF = (OPA_W'(1) << FRAC_BITS) >> 1;

   state_type                state_ff, state_in;
   logic                     issued_ff, issued_in;
   logic [1:0]               axis_ff, axis_in;
   logic [2:0]               pair_ff, pair_in;
   logic signed [MEAN_W-1:0] mean_ff [3];
   logic signed [MEAN_W-1:0] mean_in [3];
   logic signed [COV_W-1:0]  cov_ff [6];
   logic signed [COV_W-1:0]  cov_in [6];
   logic [TOT_W-1:0]         tot_ff, tot_in;
   logic                     fault_ff, fault_in;
   logic signed [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [WEIGHT_BITS-1:0]   w_ff, w_in;
   logic [TOT_W-1:0]         wold_ff, wold_in;
   logic [SUM_W-1:0]         v_ff, v_in;
   logic signed [COV_W:0]    t1_ff, t1_in;
   logic [OPA_W-1:0]         p_ff, p_in;

   wpcc_arith_req_type       arith_req;
   wpcc_arith_rsp_type       arith_rsp;

   logic signed [DIFF_W-1:0] d_axis, d_a, d_b;
   logic signed [COV_W-1:0]  cur_cov;
   logic [TOT_W-1:0]         base_w;
   logic [SUM_W-1:0]         new_v;
   logic [MEAN_W-1:0]        quo;
   logic [COV_W:0]           t1_mag;
   logic signed [COV_W+1:0]  t1_ext, t2_ext, sum;
   logic                     compute;

   function automatic logic [DIFF_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
      return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
   endfunction

   function automatic logic [COV_W-1:0] mag_cov(input logic signed [COV_W-1:0] v);
      return v[COV_W-1] ? COV_W'(-v) : COV_W'(v);
   endfunction

   wpcc_arith u_arith (
      .clock (clock),
      .reset (reset),
      .req   (arith_req),
      .rsp   (arith_rsp)
   );

   // Operand selection for the mean axis and for the pair being worked on: xx, yy, zz, xy, yz, zx.
   always_comb begin
      case (axis_ff)
         2'd0:    d_axis = dx_ff;
         2'd1:    d_axis = dy_ff;
         default: d_axis = dz_ff;
      endcase
      case (pair_ff)
         3'd0:    begin d_a = dx_ff; d_b = dx_ff; end
         3'd1:    begin d_a = dy_ff; d_b = dy_ff; end
         3'd2:    begin d_a = dz_ff; d_b = dz_ff; end
         3'd3:    begin d_a = dx_ff; d_b = dy_ff; end
         3'd4:    begin d_a = dy_ff; d_b = dz_ff; end
         default: begin d_a = dz_ff; d_b = dx_ff; end
      endcase
      cur_cov = cov_ff[pair_ff];
   end

   assign compute = (state_ff != ST_IDLE) && (state_ff != ST_DONE);

   always_comb begin
      arith_req.start = compute && !issued_ff;
      arith_req.op    = AR_MUL;
      arith_req.a     = '0;
      arith_req.b     = '0;
      case (state_ff)
         ST_MEAN_MUL: begin
            arith_req.a = OPA_W'(mag_diff(d_axis));
            arith_req.b = OPB_W'(w_ff);
         end
         ST_T1_MUL: begin
            arith_req.a = OPA_W'(mag_cov(cur_cov));
            arith_req.b = OPB_W'(wold_ff);
         end
         ST_DD_MUL: begin
            arith_req.a = OPA_W'(mag_diff(d_a));
            arith_req.b = OPB_W'(mag_diff(d_b));
         end
         ST_PW_MUL: begin
            arith_req.a = p_ff;
            arith_req.b = OPB_W'(w_ff);
         end
         ST_PWW_MUL: begin
            arith_req.a = arith_rsp.result;
            arith_req.b = OPB_W'(wold_ff);
         end
         ST_MEAN_DIV, ST_T1_DIV, ST_PW_DIV, ST_PWW_DIV: begin
            arith_req.op = AR_DIV;
            arith_req.a  = arith_rsp.result;
            arith_req.b  = OPB_W'(v_ff);
         end
         default: begin
            arith_req.a = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      axis_in   = axis_ff;
      pair_in   = pair_ff;
      mean_in   = mean_ff;
      cov_in    = cov_ff;
      tot_in    = tot_ff;
      fault_in  = fault_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      dz_in     = dz_ff;
      w_in      = w_ff;
      wold_in   = wold_ff;
      v_in      = v_ff;
      t1_in     = t1_ff;
      p_in      = p_ff;
      base_w    = in_point.start_new ? '0 : tot_ff;
      new_v     = {1'b0, base_w} + SUM_W'(in_point.weight);
      quo       = arith_rsp.result[MEAN_W-1:0];
      t1_mag    = arith_rsp.result[COV_W:0];
      t1_ext    = (COV_W+2)'(t1_ff);
      t2_ext    = signed'({1'b0, arith_rsp.result[COV_W:0]});
      sum       = (d_a[DIFF_W-1] ^ d_b[DIFF_W-1]) ? t1_ext - t2_ext : t1_ext + t2_ext;
      in_ready  = (state_ff == ST_IDLE);
      out_valid = (state_ff == ST_DONE);

      if (compute && arith_req.start) begin
         issued_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               if (in_point.start_new) begin
                  for (int i = 0; i < 3; i++) mean_in[i] = '0;
                  for (int i = 0; i < 6; i++) cov_in[i] = '0;
                  tot_in = '0;
               end
               dx_in   = (DIFF_W'(in_point.x) <<< FRAC_BITS) - DIFF_W'(mean_in[0]);
               dy_in   = (DIFF_W'(in_point.y) <<< FRAC_BITS) - DIFF_W'(mean_in[1]);
               dz_in   = (DIFF_W'(in_point.z) <<< FRAC_BITS) - DIFF_W'(mean_in[2]);
               w_in    = in_point.weight;
               wold_in = base_w;
               v_in    = new_v;
               axis_in = 2'd0;
               pair_in = 3'd0;
               if (in_point.weight == '0) begin
                  // A zero weight adds nothing (start_new still clears); an empty cluster faults.
                  fault_in = (base_w == '0);
                  state_in = ST_DONE;
               end else begin
                  fault_in = new_v[SUM_W-1];
                  tot_in   = new_v[SUM_W-1] ? '1 : new_v[TOT_W-1:0];
                  state_in = ST_MEAN_MUL;
               end
            end
         end
         ST_DONE: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            if (issued_ff && arith_rsp.done) begin
               issued_in = 1'b0;
               case (state_ff)
                  ST_MEAN_MUL: state_in = ST_MEAN_DIV;
                  ST_MEAN_DIV: begin
                     mean_in[axis_ff] = d_axis[DIFF_W-1] ? mean_ff[axis_ff] - quo
                                                        : mean_ff[axis_ff] + quo;
                     if (axis_ff == 2'd2) begin
                        state_in = (wold_ff == '0) ? ST_DONE : ST_T1_MUL;
                     end else begin
                        axis_in  = axis_ff + 2'd1;
                        state_in = ST_MEAN_MUL;
                     end
                  end
                  ST_T1_MUL: state_in = ST_T1_DIV;
                  ST_T1_DIV: begin
                     t1_in    = cur_cov[COV_W-1] ? (COV_W+1)'(-t1_mag) : t1_mag;
                     state_in = ST_DD_MUL;
                  end
                  ST_DD_MUL: begin
                     p_in     = (arith_rsp.result + RND_HALF) >> FRAC_BITS;
                     state_in = ST_PW_MUL;
                  end
                  ST_PW_MUL:  state_in = ST_PW_DIV;
                  ST_PW_DIV:  state_in = ST_PWW_MUL;
                  ST_PWW_MUL: state_in = ST_PWW_DIV;
                  ST_PWW_DIV: begin
                     if (pair_ff < 3'd3 && sum < 0) begin
                        cov_in[pair_ff] = '0;
                        fault_in        = 1'b1;
                     end else if (sum > COV_HI) begin
                        cov_in[pair_ff] = COV_HI[COV_W-1:0];
                        fault_in        = 1'b1;
                     end else if (sum < COV_LO) begin
                        cov_in[pair_ff] = COV_LO[COV_W-1:0];
                        fault_in        = 1'b1;
                     end else begin
                        cov_in[pair_ff] = sum[COV_W-1:0];
                     end
                     if (pair_ff == 3'd5) begin
                        state_in = ST_DONE;
                     end else begin
                        pair_in  = pair_ff + 3'd1;
                        state_in = ST_T1_MUL;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dz_ff   <= dz_in;
      w_ff    <= w_in;
      wold_ff <= wold_in;
      v_ff    <= v_in;
      t1_ff   <= t1_in;
      p_ff    <= p_in;
      axis_ff <= axis_in;
      pair_ff <= pair_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
         for (int i = 0; i < 3; i++) mean_ff[i] <= '0;
         for (int i = 0; i < 6; i++) cov_ff[i] <= '0;
         tot_ff    <= '0;
         fault_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         mean_ff   <= mean_in;
         cov_ff    <= cov_in;
         tot_ff    <= tot_in;
         fault_ff  <= fault_in;
      end
   end

   assign result.mean_x     = mean_ff[0];
   assign result.mean_y     = mean_ff[1];
   assign result.mean_z     = mean_ff[2];
   assign result.weight_sum = tot_ff;
   assign result.var_xx     = cov_ff[0][VAR_W-1:0];
   assign result.var_yy     = cov_ff[1][VAR_W-1:0];
   assign result.var_zz     = cov_ff[2][VAR_W-1:0];
   assign result.cov_xy     = cov_ff[3];
   assign result.cov_yz     = cov_ff[4];
   assign result.cov_zx     = cov_ff[5];
   assign result.fault      = fault_ff;

   `ASSERT_ALWAYS(a_diag_nonneg, clock, reset, !cov_ff[0][COV_W-1] && !cov_ff[1][COV_W-1] && !cov_ff[2][COV_W-1], "diagonal covariance went negative")
   `ASSERT_IMPLY(a_empty_zero, clock, reset, tot_ff == '0, cov_ff[0] == '0 && cov_ff[1] == '0 && cov_ff[2] == '0 && cov_ff[3] == '0 && cov_ff[4] == '0 && cov_ff[5] == '0, "empty cluster holds covariance")
   `ASSERT_IMPLY(a_start_idle, clock, reset, arith_req.start, !arith_rsp.busy, "shared unit started while busy")
   `ASSERT_IMPLY(a_done_issued, clock, reset, arith_rsp.done, issued_ff, "shared unit finished an operation nobody issued")

endmodule

@@ hw/rtl/weighted_point_cluster_covariance.sv @@
// Top level of the weighted point cluster covariance block: stream ports and result register.
//
//   Channel  Direction  tdata (low bit up)                            tuser
//   req      in         point_x, point_y, point_z, point_weight        start_new
//   rsp      out        mean_x/y/z, weight_sum, var_xx/yy/zz, cov_*    fault
//
// A point runs 3 multiply-divide pairs for the mean and 6 x (4 multiplies +
// 3 divides) for the covariance, all on one bit-serial unit. A point on an
// empty cluster runs only the mean steps, and a zero-weight point goes straight
// to its result. Reset is synchronous and clears the cluster. A result waits in
// the output register while the next point runs.
module weighted_point_cluster_covariance import wpcc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // point_x, point_y, point_z, point_weight
   input  logic [0:0]             req_tuser,   // start_new
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // mean_x, mean_y, mean_z, weight_sum, var_xx,
                                               // var_yy, var_zz, cov_xy, cov_yz, cov_zx
   output logic [0:0]             rsp_tuser    // fault
);

   wpcc_point_type   point;
   wpcc_result_type  res;
   logic             core_valid, core_ready;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_user_ff, rsp_user_in;

   assign point.x         = req_tdata[COORD_BITS-1:0];
   assign point.y         = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign point.z         = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign point.weight    = req_tdata[3*COORD_BITS+WEIGHT_BITS-1:3*COORD_BITS];
   assign point.start_new = req_tuser[0];

   wpcc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_point  (point),
      .out_valid (core_valid),
      .out_ready (core_ready),
      .result    (res)
   );

   assign core_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (core_valid && core_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_TDATA_W'({res.cov_zx, res.cov_yz, res.cov_xy,
                                      res.var_zz, res.var_yy, res.var_xx, res.weight_sum,
                                      res.mean_z, res.mean_y, res.mean_x});
         rsp_user_in  = res.fault;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule
